[src/local_radius_index_histogram_defines.svh]
// assertion macros for the local radius index histogram block
`ifndef LOCAL_RADIUS_INDEX_HISTOGRAM_DEFINES_SVH
`define LOCAL_RADIUS_INDEX_HISTOGRAM_DEFINES_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define LRIH_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define LRIH_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define LRIH_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRIH_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

[src/lrih_pkg.sv]
// shared types and constants of the local radius index histogram
package lrih_pkg;

	localparam int FUNC_W = 2;
	localparam int DIR_W  = 3;
	localparam int BIN_W  = 4;
	localparam int DIFF_W = 9;
	localparam int CNT_W  = 32;
	localparam int THR_W  = 10;

	localparam logic [FUNC_W-1:0] FUNC_ACC   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	localparam logic REG_EDGE_THR = 1'b0;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// classified work item passed from front to back
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [DIR_W-1:0]  direction;
		logic [BIN_W-1:0]  bin;
		logic              bad;
	} lrih_item_t;

	// back-end status seen by the top level checks
	typedef struct packed {
		logic              issue;
		logic [FUNC_W-1:0] func;
		logic              dir_ok;
		logic              valid_any;
		logic [CNT_W-1:0]  count;
	} lrih_back_stat_t;

endpackage

[src/lrih_ifs.sv]
// valid/ready channel interfaces for the input and result beats
interface lrih_in_if import lrih_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [DIR_W-1:0]         direction;
	logic [BIN_W-1:0]         bin_select;
	logic signed [DIFF_W-1:0] diff_adjacent;
	logic signed [DIFF_W-1:0] diff_second;
	logic signed [DIFF_W-1:0] diff_third;
	logic signed [DIFF_W-1:0] diff_fourth;
	logic signed [DIFF_W-1:0] diff_fifth;

	modport source (
		output valid, func, direction, bin_select,
		output diff_adjacent, diff_second, diff_third, diff_fourth, diff_fifth,
		input  ready
	);
	modport sink (
		input  valid, func, direction, bin_select,
		input  diff_adjacent, diff_second, diff_third, diff_fourth, diff_fifth,
		output ready
	);
endinterface

interface lrih_out_if import lrih_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] chosen_bin;
	logic [CNT_W-1:0] bin_count;
	logic             bad_request;

	modport source (output valid, chosen_bin, bin_count, bad_request, input ready);
	modport sink (input valid, chosen_bin, bin_count, bad_request, output ready);
endinterface

[src/lrih_front.sv]
// front end: accepts beats and picks the bin from the difference run
module lrih_front import lrih_pkg::*; #(
	parameter int MAX_RUN = 4
) (
	lrih_in_if.sink          in_ch,
	input  logic [THR_W-1:0] thr,
	input  logic             q_full,
	output logic             push,
	output lrih_item_t       item
);

	localparam int BINS = 2 * MAX_RUN + 1;
	localparam logic [BIN_W-1:0] CENTER = BIN_W'(MAX_RUN);
	localparam logic [2:0] RUN_CAP = 3'(MAX_RUN);

	logic signed [DIFF_W-1:0] d [5];
	logic [4:0]               flat;
	logic [DIFF_W-1:0]        mag [5];
	logic                     up;
	logic                     going;
	logic [2:0]               run;
	logic [2:0]               run_cap;
	logic [BIN_W-1:0]         acc_bin;

	assign d[0] = in_ch.diff_adjacent;
	assign d[1] = in_ch.diff_second;
	assign d[2] = in_ch.diff_third;
	assign d[3] = in_ch.diff_fourth;
	assign d[4] = in_ch.diff_fifth;

	// flat when four times the magnitude is below the threshold
	always_comb begin
		for (int k = 0; k < 5; k++) begin
			mag[k]  = d[k][DIFF_W-1] ? (~d[k] + 1'b1) : d[k];
			flat[k] = {mag[k], 2'b00} < {1'b0, thr};
		end
	end

	// run of same-sign edge differences after the adjacent one
	always_comb begin
		up    = d[0][DIFF_W-1];
		going = 1'b1;
		run   = 3'd1;
		for (int k = 1; k <= MAX_RUN; k++) begin
			if (going && !flat[k] &&
			    (up ? d[k][DIFF_W-1] : (!d[k][DIFF_W-1] && d[k] != '0))) begin
				run = run + 3'd1;
			end else begin
				going = 1'b0;
			end
		end
		run_cap = (run > RUN_CAP) ? RUN_CAP : run;
		if (flat[0]) begin
			acc_bin = CENTER;
		end else if (up) begin
			acc_bin = CENTER + BIN_W'(run_cap);
		end else begin
			acc_bin = CENTER - BIN_W'(run_cap);
		end
	end

	always_comb begin
		item.func      = in_ch.func;
		item.direction = in_ch.direction;
		item.bin       = '0;
		item.bad       = 1'b0;
		unique case (in_ch.func)
			FUNC_ACC: begin
				item.bin = acc_bin;
			end
			FUNC_READ: begin
				item.bin = in_ch.bin_select;
				item.bad = 32'(in_ch.bin_select) >= BINS;
			end
			default: begin
			end
		endcase
	end

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

endmodule

[src/lrih_queue.sv]
// two-entry queue between front and back
module lrih_queue import lrih_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  lrih_item_t push_item,
	output logic       full,
	input  logic       pop,
	output lrih_item_t head,
	output logic       empty
);

	lrih_item_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	assign head  = slot_q[rd_ptr_q];
	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;

endmodule

[src/lrih_back.sv]
// back end: read-modify-write of the count store and result register
module lrih_back import lrih_pkg::*; #(
	parameter int MAX_RUN        = 4,
	parameter int NUM_DIRECTIONS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  lrih_item_t      head,
	output logic            pop,
	lrih_out_if.source      out_ch,
	output lrih_back_stat_t stat
);

	localparam int BINS  = 2 * MAX_RUN + 1;
	localparam int DEPTH = NUM_DIRECTIONS * BINS;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_WB   = 2'd2;

	logic [1:0]       state_q;
	lrih_item_t       work_q;
	logic [CNT_W-1:0] mem_q [DEPTH];
	logic [CNT_W-1:0] rdata_q;
	logic [DEPTH-1:0] vld_q;
	logic             out_valid_q;
	logic [BIN_W-1:0] out_bin_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_bad_q;

	logic [AW-1:0]    addr;
	logic             dir_ok;
	logic [CNT_W-1:0] old_cnt;
	logic [CNT_W-1:0] inc_cnt;
	logic [CNT_W-1:0] new_cnt;
	logic             issue;
	logic             we;

	assign addr   = AW'(32'(work_q.direction) * BINS + 32'(work_q.bin));
	assign dir_ok = 32'(work_q.direction) < NUM_DIRECTIONS;
	assign pop    = (state_q == ST_IDLE) && !q_empty;
	assign issue  = (state_q == ST_WB) && (!out_valid_q || out_ch.ready);

	// entries never written since the last clear read as zero
	always_comb begin
		old_cnt = '0;
		if (dir_ok && !work_q.bad && vld_q[addr]) begin
			old_cnt = rdata_q;
		end
		inc_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
		new_cnt = '0;
		we      = 1'b0;
		case (work_q.func)
			FUNC_ACC: begin
				new_cnt = dir_ok ? inc_cnt : '0;
				we      = issue && dir_ok;
			end
			FUNC_READ: begin
				new_cnt = old_cnt;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (issue) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (issue && work_q.func == FUNC_CLEAR) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[addr] <= 1'b1;
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= head;
		end
		if (issue) begin
			out_bin_q <= work_q.bin;
			out_cnt_q <= new_cnt;
			out_bad_q <= work_q.bad;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= new_cnt;
		end
		rdata_q <= mem_q[addr];
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.chosen_bin  = out_bin_q;
	assign out_ch.bin_count   = out_cnt_q;
	assign out_ch.bad_request = out_bad_q;

	assign stat.issue     = issue;
	assign stat.func      = work_q.func;
	assign stat.dir_ok    = dir_ok;
	assign stat.valid_any = |vld_q;
	assign stat.count     = new_cnt;

endmodule

[src/local_radius_index_histogram.sv]
// a taken beat passes the queue slot, work register, count store read register and result
//   register; the back end takes one beat at a time through its idle, read and write-back
//   states around the single-port count store; the 2-entry queue absorbs short input bursts
// reset: counts read as zero at once through per-entry valid bits cleared by arst_n,
//   threshold register goes to zero, no clearing pass is needed
// a clear beat drops every valid bit at once, on its write-back step
`include "local_radius_index_histogram_defines.svh"

module local_radius_index_histogram import lrih_pkg::*; #(
	parameter int MAX_RUN        = 4,
	parameter int NUM_DIRECTIONS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	lrih_in_if.sink     in_ch,
	lrih_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int BINS = 2 * MAX_RUN + 1;

	// edge threshold register, quarter grey levels
	logic [THR_W-1:0] thr_q;

	// front to queue
	logic             push;
	lrih_item_t       push_item;
	logic             q_full;

	// queue to back
	logic             pop;
	lrih_item_t       head;
	logic             q_empty;

	lrih_back_stat_t  stat;

	// apb: write in the access phase, no wait states
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_EDGE_THR) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_EDGE_THR) ? {{(32 - THR_W){1'b0}}, thr_q} : '0;

	// front: classify each beat into a bin and push it on the queue
	lrih_front #(
		.MAX_RUN (MAX_RUN)
	) u_front (
		.in_ch  (in_ch),
		.thr    (thr_q),
		.q_full (q_full),
		.push   (push),
		.item   (push_item)
	);

	// short queue so the front keeps taking beats while the back works
	lrih_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	// back: count store update and result register
	lrih_back #(
		.MAX_RUN        (MAX_RUN),
		.NUM_DIRECTIONS (NUM_DIRECTIONS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.out_ch  (out_ch),
		.stat    (stat)
	);

	// a result only appears after a write-back step
	`LRIH_ASSERT(a_rise_after_issue, clk, arst_n, $rose(out_ch.valid) |-> $past(stat.issue), "result without write-back")
	// clear leaves no valid entry behind
	`LRIH_ASSERT(a_clear_empties, clk, arst_n, stat.issue && stat.func == FUNC_CLEAR |=> !stat.valid_any, "clear left valid entries")
	// a counted accumulate never reports zero, saturation included
	`LRIH_ASSERT_NEVER(a_acc_nonzero, clk, arst_n, stat.issue && stat.func == FUNC_ACC && stat.dir_ok && stat.count == '0, "accumulate count wrapped")
	// a bad request names a bin past the top and carries no count
	`LRIH_ASSERT(a_bad_shape, clk, arst_n, out_ch.valid && out_ch.bad_request |-> 32'(out_ch.chosen_bin) >= BINS && out_ch.bin_count == '0, "bad request shape")

endmodule

[verif/tb_top.sv]
// self-checking testbench for the local radius index texture histogram block
`timescale 1ns / 100ps

module tb_top import lrih_pkg::*; ();

	localparam int MAX_RUN  = 4;
	localparam int NUM_DIR  = 8;
	localparam int BINS     = 2 * MAX_RUN + 1;
	// block's input-to-result delay, used as the base of the settle margin
	localparam int LATENCY  = 3;
	localparam int PHASES   = 8;
	localparam int PHASE_LEN = 165;
	// generous bound in ns: every beat waiting out the longest gap and stall plus the block's own delay
	localparam int LIMIT_NS = 400_000;

	// unused func code, not named in the package
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	// edge threshold register is index 0 of the register map, 4-byte stride
	localparam logic [2:0] THR_ADDR = 3'(REG_EDGE_THR) << 2;

	// one request beat as the source sees it
	typedef struct {
		logic [FUNC_W-1:0]        func;
		logic [DIR_W-1:0]         direction;
		logic [BIN_W-1:0]         bin_select;
		logic signed [DIFF_W-1:0] diff [5];
	} hist_req_t;

	// one result beat
	typedef struct packed {
		logic [BIN_W-1:0] bin;
		logic [CNT_W-1:0] count;
		logic             bad;
	} hist_resp_t;

	// keeps its own copy of the count store and threshold, predicts every result in order
	class hist_scoreboard;
		logic [CNT_W-1:0] counts [NUM_DIR*BINS];
		int unsigned      edge_thr;
		hist_resp_t       pending [$];
		int errors, checked;
		int n_acc, n_read, n_bad, n_clear, n_unused;

		function new();
			foreach (counts[i]) counts[i] = '0;
			edge_thr = 0;
		endfunction

		// flat when four times the magnitude is below the threshold
		function bit is_flat(logic signed [DIFF_W-1:0] v);
			int m;
			m = (v < 0) ? -int'(v) : int'(v);
			return (m * 4) < int'(edge_thr);
		endfunction

		// bin picked by the signed run of edge differences
		function logic [BIN_W-1:0] radius_bin(hist_req_t r);
			bit up;
			int run;
			if (is_flat(r.diff[0]))
				return BIN_W'(MAX_RUN);
			// negative adjacent difference counts upward, zero or positive counts downward
			up = r.diff[0] < 0;
			run = 1;
			for (int k = 1; k <= MAX_RUN; k++) begin
				if (is_flat(r.diff[k]))
					break;
				if ((up && r.diff[k] < 0) || (!up && r.diff[k] > 0))
					run++;
				else
					break;
			end
			if (run > MAX_RUN)
				run = MAX_RUN;
			return up ? BIN_W'(MAX_RUN + run) : BIN_W'(MAX_RUN - run);
		endfunction

		function void note_input(hist_req_t r);
			hist_resp_t e;
			int idx;
			e = '0;
			case (r.func)
				FUNC_ACC: begin
					n_acc++;
					e.bin = radius_bin(r);
					if (r.direction < NUM_DIR) begin
						idx = int'(r.direction) * BINS + int'(e.bin);
						if (counts[idx] != COUNT_MAX)
							counts[idx]++;
						e.count = counts[idx];
					end
				end
				FUNC_READ: begin
					n_read++;
					e.bin = r.bin_select;
					if (r.bin_select >= BINS) begin
						e.bad = 1'b1;
						n_bad++;
					end else if (r.direction < NUM_DIR)
						e.count = counts[int'(r.direction) * BINS + int'(r.bin_select)];
				end
				FUNC_CLEAR: begin
					n_clear++;
					foreach (counts[i]) counts[i] = '0;
				end
				default: n_unused++;
			endcase
			pending = {pending, e};
		endfunction

		function void check_result(hist_resp_t got);
			hist_resp_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat bin %0d count %0d bad %0b",
					$time, got.bin, got.count, got.bad);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.bin !== e.bin) begin
				errors++;
				$display("%0t: chosen_bin expected %0d actual %0d", $time, e.bin, got.bin);
			end
			if (got.count !== e.count) begin
				errors++;
				$display("%0t: bin_count expected %0d actual %0d", $time, e.count, got.count);
			end
			if (got.bad !== e.bad) begin
				errors++;
				$display("%0t: bad_request expected %0b actual %0b", $time, e.bad, got.bad);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lrih_in_if  in_ch ();
	lrih_out_if out_ch ();

	hist_scoreboard sb = new();

	// quiet phases run with no idling on either side
	bit              quiet;
	// direction most beats go to, so counts build up and back-to-back hits happen
	logic [DIR_W-1:0] hot_dir;
	int              reg_errors;
	int              n_settings;

	local_radius_index_histogram #(
		.MAX_RUN        (MAX_RUN),
		.NUM_DIRECTIONS (NUM_DIR)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// smallest magnitude that is an edge at the current threshold
	function automatic int edge_floor();
		return (int'(sb.edge_thr) + 3) / 4;
	endfunction

	// magnitude that counts as an edge, often right on the boundary
	function automatic int edge_mag();
		int lo;
		lo = edge_floor();
		if (lo < 1)
			lo = 1;
		// threshold so high that nothing can be an edge
		if (lo > 255)
			return $urandom_range(0, 255);
		return ($urandom_range(0, 2) == 0) ? lo : $urandom_range(lo, 255);
	endfunction

	// magnitude that counts as flat, often just under the boundary
	function automatic int flat_mag();
		int lo;
		lo = edge_floor();
		// zero threshold: nothing is flat, a zero still breaks a run
		if (lo == 0)
			return 0;
		if (lo > 255)
			return $urandom_range(0, 255);
		return ($urandom_range(0, 2) == 0) ? lo - 1 : $urandom_range(0, lo - 1);
	endfunction

	function automatic logic signed [DIFF_W-1:0] signed_diff(int m, bit neg);
		return neg ? DIFF_W'(-m) : DIFF_W'(m);
	endfunction

	function automatic hist_req_t acc_item(logic [DIR_W-1:0] dir, int d0, int d1, int d2,
		int d3, int d4);
		hist_req_t r;
		r.func       = FUNC_ACC;
		r.direction  = dir;
		r.bin_select = '0;
		r.diff[0] = DIFF_W'(d0);
		r.diff[1] = DIFF_W'(d1);
		r.diff[2] = DIFF_W'(d2);
		r.diff[3] = DIFF_W'(d3);
		r.diff[4] = DIFF_W'(d4);
		return r;
	endfunction

	function automatic hist_req_t op_item(logic [FUNC_W-1:0] f, logic [DIR_W-1:0] dir,
		logic [BIN_W-1:0] sel);
		hist_req_t r;
		r = acc_item(dir, 0, 0, 0, 0, 0);
		r.func       = f;
		r.bin_select = sel;
		return r;
	endfunction

	// mostly well-formed runs of chosen length and polarity, the rest noise, reads, clears and unused codes
	function automatic hist_req_t random_item();
		hist_req_t r;
		int pick;
		int run_len;
		bit up;
		r.func       = FUNC_ACC;
		r.direction  = ($urandom_range(0, 9) < 4) ? hot_dir : DIR_W'($urandom_range(0, 7));
		r.bin_select = BIN_W'($urandom_range(0, 15));
		foreach (r.diff[i])
			r.diff[i] = DIFF_W'($urandom_range(0, 510) - 255);
		pick = $urandom_range(0, 99);
		if (pick < 72) begin
			up = 1'($urandom_range(0, 1));
			run_len = $urandom_range(0, MAX_RUN);
			if ($urandom_range(0, 9) == 0)
				r.diff[0] = signed_diff(flat_mag(), 1'($urandom_range(0, 1)));
			else if (!up && sb.edge_thr == 0 && $urandom_range(0, 5) == 0)
				r.diff[0] = '0;
			else
				r.diff[0] = signed_diff(edge_mag(), up);
			for (int k = 1; k <= MAX_RUN; k++) begin
				if (k <= run_len)
					r.diff[k] = signed_diff(edge_mag(), up);
				else if (k == run_len + 1) begin
					// break the run: flat, zero or opposite sign
					case ($urandom_range(0, 2))
						0: r.diff[k] = signed_diff(flat_mag(), 1'($urandom_range(0, 1)));
						1: r.diff[k] = '0;
						default: r.diff[k] = signed_diff(edge_mag(), !up);
					endcase
				end
			end
		end else if (pick < 82) begin
			// noise accumulate, diffs already random
		end else if (pick < 97) begin
			r.func = FUNC_READ;
			r.bin_select = ($urandom_range(0, 3) == 0) ? BIN_W'($urandom_range(BINS, 15))
				: BIN_W'($urandom_range(0, BINS - 1));
		end else if (pick == 97)
			r.func = FUNC_UNUSED;
		else
			r.func = FUNC_CLEAR;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// one input beat, with a random number of idle cycles ahead of it
	task automatic send_item(input hist_req_t r);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.func          <= r.func;
		in_ch.direction     <= r.direction;
		in_ch.bin_select    <= r.bin_select;
		in_ch.diff_adjacent <= r.diff[0];
		in_ch.diff_second   <= r.diff[1];
		in_ch.diff_third    <= r.diff[2];
		in_ch.diff_fourth   <= r.diff[3];
		in_ch.diff_fifth    <= r.diff[4];
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_input(r);
	endtask

	// stop sending and wait until every expected result has come back
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// setup cycle then access cycle, held until pready
	task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write the threshold while idle, then read it back
	task automatic set_threshold(input int unsigned t);
		logic [31:0] rd;
		settle();
		apb_xfer(1'b1, THR_ADDR, 32'(t), rd);
		sb.edge_thr = t;
		n_settings++;
		apb_xfer(1'b0, THR_ADDR, '0, rd);
		if (rd !== 32'(t)) begin
			reg_errors++;
			$display("%0t: threshold readback expected %0d actual %0d", $time, t, rd);
		end
	endtask

	// ---------------------------------------------------------------
	// result side: random stalls, every beat checked in order
	// ---------------------------------------------------------------
	initial begin
		hist_resp_t got;
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid)
				@(posedge clk);
			got.bin   = out_ch.chosen_bin;
			got.count = out_ch.bin_count;
			got.bad   = out_ch.bad_request;
			sb.check_result(got);
		end
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		int unsigned thr_plan [PHASES];
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		in_ch.valid         <= 1'b0;
		in_ch.func          <= FUNC_ACC;
		in_ch.direction     <= '0;
		in_ch.bin_select    <= '0;
		in_ch.diff_adjacent <= '0;
		in_ch.diff_second   <= '0;
		in_ch.diff_third    <= '0;
		in_ch.diff_fourth   <= '0;
		in_ch.diff_fifth    <= '0;
		quiet   = 1'b1;
		hot_dir = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset threshold of zero: nothing is flat
		send_item(op_item(FUNC_READ, 3'd0, 4'(MAX_RUN)));         // empty store after reset
		send_item(acc_item(3'd0, 0, 0, 0, 0, 0));                  // zero adjacent goes downward
		send_item(acc_item(3'd0, -255, -255, -255, -255, -255));   // long upward run, capped
		send_item(acc_item(3'd0, 255, 255, 255, 255, 255));        // long downward run, capped
		send_item(acc_item(3'd0, 1, -1, 1, 1, 1));                 // sign flip ends the run
		send_item(acc_item(3'd0, -1, -1, 0, -1, -1));              // zero later diff ends the run
		send_item(acc_item(3'd0, 255, 255, 255, 0, 255));
		// same bin back to back, exercises the count store read after its own write-back
		repeat (3) send_item(acc_item(3'd7, -3, -3, -3, -3, 5));
		send_item(op_item(FUNC_READ, 3'd7, 4'(2 * MAX_RUN)));
		send_item(op_item(FUNC_READ, 3'd0, 4'(MAX_RUN - 1)));
		send_item(op_item(FUNC_READ, 3'd0, 4'(BINS)));             // first bin past the end
		send_item(op_item(FUNC_READ, 3'd5, 4'd15));                // largest select
		send_item(op_item(FUNC_UNUSED, 3'd7, 4'd15));
		send_item(op_item(FUNC_CLEAR, 3'd0, 4'd0));
		send_item(op_item(FUNC_READ, 3'd7, 4'(2 * MAX_RUN)));      // cleared
		// top threshold: every difference is flat
		set_threshold(1023);
		send_item(acc_item(3'd1, 255, 255, 255, 255, 255));
		send_item(acc_item(3'd1, -255, -255, -255, -255, -255));
		// threshold of one grey level: magnitude one is just an edge, zero is flat
		set_threshold(4);
		send_item(acc_item(3'd2, 1, 1, 1, 0, 1));
		send_item(acc_item(3'd2, 0, 255, 255, 255, 255));
		send_item(acc_item(3'd2, -1, -2, -255, -1, -7));
		send_item(op_item(FUNC_READ, 3'd2, 4'(MAX_RUN - 3)));
		send_item(op_item(FUNC_READ, 3'd3, 4'd0));

		// random part: one threshold per phase, extremes included
		thr_plan = '{0, 1023, 1, 4, 0, 512, 0, 0};
		thr_plan[4] = $urandom_range(2, 1022);
		thr_plan[6] = $urandom_range(2, 1022);
		thr_plan[7] = $urandom_range(2, 1022);
		for (int p = 0; p < PHASES; p++) begin
			set_threshold(thr_plan[p]);
			quiet   = (p % 3 == 1);
			hot_dir = DIR_W'($urandom_range(0, 7));
			repeat (PHASE_LEN) begin
				if ($urandom_range(0, 49) == 0)
					hot_dir = DIR_W'($urandom_range(0, 7));
				send_item(random_item());
			end
		end
		settle();

		$display("covered %0d accumulate, %0d read (%0d out of range), %0d clear, %0d unused-code beats",
			sb.n_acc, sb.n_read, sb.n_bad, sb.n_clear, sb.n_unused);
		$display("%0d results checked over %0d threshold settings", sb.checked, n_settings);
		if (sb.errors == 0 && reg_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[local_radius_index_histogram.f]
+incdir+src
src/lrih_pkg.sv
src/lrih_ifs.sv
src/lrih_front.sv
src/lrih_queue.sv
src/lrih_back.sv
src/local_radius_index_histogram.sv
verif/tb_top.sv
